// File: rtl/dual_lidar_scan_merge_macros.svh
// Assertion macros shared by the scan merge checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef DUAL_LIDAR_SCAN_MERGE_MACROS_SVH
`define DUAL_LIDAR_SCAN_MERGE_MACROS_SVH

// same-cycle implication, off during reset
`define DLSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define DLSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/dlsm_pkg.sv
// Package for the dual lidar scan merge: types, constants, CORDIC table.
// No dependencies; used by dual_lidar_scan_merge.
package dlsm_pkg;

  localparam int BUCKETS_DEF  = 1024;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam int DW           = 30;   // coordinate width, mm with 8 fraction bits
  localparam int ZW           = 26;   // angle width, 2^-24 turn

  localparam logic [16:0]          INV_GAIN  = 17'd39797;
  localparam logic [15:0]          MIN_RANGE = 16'd50;
  localparam logic [15:0]          MERGE_MM  = 16'd30;
  localparam logic signed [ZW-1:0] HALF_TURN = 26'sd8388608;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_CLEAR  = 2'd0;
  localparam opcode_t OP_SAMPLE = 2'd1;
  localparam opcode_t OP_READ   = 2'd2;

  localparam logic [2:0] CFG_MOUNT_A = 3'd0;
  localparam logic [2:0] CFG_OFSX_A  = 3'd1;
  localparam logic [2:0] CFG_OFSY_A  = 3'd2;
  localparam logic [2:0] CFG_MOUNT_B = 3'd3;
  localparam logic [2:0] CFG_OFSX_B  = 3'd4;
  localparam logic [2:0] CFG_OFSY_B  = 3'd5;
  localparam logic [2:0] CFG_LOW_LIM = 3'd6;
  localparam logic [2:0] CFG_HIGH_LIM = 3'd7;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ROT, S_GAINX, S_GAINY, S_PREP, S_VEC, S_MAG,
    S_BIN, S_MRG, S_RDW, S_RDO, S_ZERO
  } state_t;

  // arctangent of 2^-i in 2^-24 turn
  function automatic logic signed [ZW-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      4'd0:    v = 26'sd2097152;
      4'd1:    v = 26'sd1238021;
      4'd2:    v = 26'sd654136;
      4'd3:    v = 26'sd332050;
      4'd4:    v = 26'sd166669;
      4'd5:    v = 26'sd83416;
      4'd6:    v = 26'sd41718;
      4'd7:    v = 26'sd20860;
      4'd8:    v = 26'sd10430;
      4'd9:    v = 26'sd5215;
      4'd10:   v = 26'sd2608;
      4'd11:   v = 26'sd1304;
      4'd12:   v = 26'sd652;
      4'd13:   v = 26'sd326;
      4'd14:   v = 26'sd163;
      4'd15:   v = 26'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/dual_lidar_scan_merge.sv
// Dual lidar scan merge top level: sequencer, shared CORDIC step, bucket memory.
// Depends on dlsm_pkg.
//
// Merges range samples of two lidars into one polar bucket array. One word is
// taken at a time; in_tready is high only while the sequencer is idle. A kept
// sample goes through accept, 16 CORDIC rotation steps, 2 gain/offset
// multiplies, a check, 16 vectoring steps (skipped for a zero point), magnitude,
// bin, and merge and write, all on one shared shift-add CORDIC stage and one
// 30x17 multiplier. A dropped sample or unused opcode goes to a zero result, a
// bucket read through a read wait and an output state. A clear rewrites the
// whole bucket memory one entry a cycle; the same sweep runs after reset, before
// in_tready first rises. Configuration writes are taken any time.
module dual_lidar_scan_merge
  import dlsm_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // sample_range, range_finite, sample_angle, read_index
  input  logic [2:0]  in_tuser,   // opcode, sensor_select
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // bin_number, bucket_value, bucket_filled, sample_placed
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW = $clog2(BUCKETS);

  // input fields
  logic [15:0] in_range, in_angle;
  logic        in_fin, in_sel;
  logic [9:0]  in_ridx;
  opcode_t     in_op;
  assign in_range = in_tdata[15:0];
  assign in_fin   = in_tdata[16];
  assign in_angle = in_tdata[32:17];
  assign in_ridx  = in_tdata[42:33];
  assign in_op    = in_tuser[1:0];
  assign in_sel   = in_tuser[2];

  // configuration registers
  logic [15:0] cfg_r [8];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[CFG_MOUNT_A]  <= 16'd8192;
      cfg_r[CFG_OFSX_A]   <= 16'd300;
      cfg_r[CFG_OFSY_A]   <= 16'd235;
      cfg_r[CFG_MOUNT_B]  <= 16'd40960;
      cfg_r[CFG_OFSX_B]   <= 16'hFED4;
      cfg_r[CFG_OFSY_B]   <= 16'hFF15;
      cfg_r[CFG_LOW_LIM]  <= 16'd50;
      cfg_r[CFG_HIGH_LIM] <= 16'd65535;
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  // sequencer and datapath registers
  state_t                state_r, state_nxt;
  logic [STEP_W-1:0]     it_r, it_nxt;
  logic [IW-1:0]         cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic                  clr_res_r, clr_res_nxt;
  logic                  rot_mode_r, rot_mode_nxt;
  logic                  sel_r, sel_nxt;
  logic [9:0]            ridx_r, ridx_nxt;
  logic signed [DW-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0]  z_r, z_nxt;
  logic [15:0]           rng_r, rng_nxt, th_r, th_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           out_data_r, out_data_nxt;

  // bucket memory: {filled, range}
  logic [16:0]   mem [BUCKETS];
  logic [16:0]   mem_rd_r;
  logic          mem_we;
  logic [IW-1:0] mem_wa, mem_ra;
  logic [16:0]   mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_r <= mem[mem_ra];
  end

  // shared CORDIC step
  logic signed [DW-1:0] xs, ys;
  logic signed [ZW-1:0] at;
  logic                 s_pos;
  assign xs    = x_r >>> it_r;
  assign ys    = y_r >>> it_r;
  assign at    = atan_lut(it_r);
  assign s_pos = rot_mode_r ? !z_r[ZW-1] : y_r[DW-1];

  // shared gain multiplier
  logic signed [DW-1:0]  mul_in, scaled;
  logic signed [DW+16:0] prod;
  assign mul_in = (state_r == S_GAINY) ? y_r : x_r;
  assign prod   = mul_in * $signed({1'b0, INV_GAIN});
  assign scaled = DW'(prod >>> 16);

  // mount offsets of the sensor in use, as mm with 8 fraction bits
  logic [15:0]          ofs_x, ofs_y;
  logic signed [DW-1:0] ofs_xq, ofs_yq;
  assign ofs_x  = sel_r ? cfg_r[CFG_OFSX_B] : cfg_r[CFG_OFSX_A];
  assign ofs_y  = sel_r ? cfg_r[CFG_OFSY_B] : cfg_r[CFG_OFSY_A];
  assign ofs_xq = {{(DW-24){ofs_x[15]}}, ofs_x, 8'd0};
  assign ofs_yq = {{(DW-24){ofs_y[15]}}, ofs_y, 8'd0};

  // sample filter and rotation start
  logic        pass;
  logic [15:0] phi, phi_q;
  logic [1:0]  q;
  logic [15:0] resu;
  logic signed [DW-1:0] rr;
  assign pass  = in_fin && (in_range >= MIN_RANGE) && (in_range >= cfg_r[CFG_LOW_LIM])
                 && (in_range <= cfg_r[CFG_HIGH_LIM]);
  assign phi   = in_angle + (in_sel ? cfg_r[CFG_MOUNT_B] : cfg_r[CFG_MOUNT_A]);
  assign phi_q = phi + 16'd8192;
  assign q     = phi_q[15:14];
  assign resu  = {phi[15:14] - q, phi[13:0]};
  assign rr    = DW'({in_range, 8'd0});

  // magnitude rounding and angle rounding
  logic signed [DW-1:0] rnd, rng_s;
  logic signed [ZW-1:0] zr;
  assign rnd   = scaled + DW'(128);
  assign rng_s = rnd >>> 8;
  assign zr    = z_r + ZW'(128);

  // bucket of the angle
  logic [15:0] t_sh;
  logic [31:0] bin_prod;
  logic [IW-1:0] idx_c;
  assign t_sh     = {~th_r[15], th_r[14:0]};
  assign bin_prod = 32'(t_sh) * 32'(BUCKETS);
  assign idx_c    = bin_prod[16 +: IW];

  // read address and range check for bucket reads
  logic [IW-1:0] ridx_a;
  logic          ridx_ok;
  assign ridx_a  = IW'(ridx_r);
  assign ridx_ok = (32'(ridx_r) < 32'(BUCKETS));

  // merge of the new range into the held bucket
  logic [15:0] cur, diff, merged;
  logic [16:0] sum;
  assign cur  = mem_rd_r[15:0];
  assign diff = (cur > rng_r) ? cur - rng_r : rng_r - cur;
  assign sum  = {1'b0, cur} + {1'b0, rng_r};
  always_comb begin
    if (!mem_rd_r[16])         merged = rng_r;
    else if (diff < MERGE_MM)  merged = sum[16:1];
    else if (rng_r < cur)      merged = rng_r;
    else                       merged = cur;
  end

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  // next state and outputs
  always_comb begin
    state_nxt     = state_r;
    it_nxt        = it_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    clr_res_nxt   = clr_res_r;
    rot_mode_nxt  = rot_mode_r;
    sel_nxt       = sel_r;
    ridx_nxt      = ridx_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    rng_nxt       = rng_r;
    th_nxt        = th_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = idx_r;
    mem_wd        = '0;
    mem_ra        = idx_r;
    in_tready     = (state_r == S_IDLE);

    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = cnt_r;
        if (cnt_r != IW'(BUCKETS - 1)) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (!clr_res_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          clr_res_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_op)
            OP_CLEAR: begin
              cnt_nxt     = '0;
              clr_res_nxt = 1'b1;
              state_nxt   = S_CLR;
            end
            OP_READ: begin
              ridx_nxt  = in_ridx;
              state_nxt = S_RDW;
            end
            OP_SAMPLE: begin
              if (pass) begin
                sel_nxt      = in_sel;
                rot_mode_nxt = 1'b1;
                it_nxt       = '0;
                x_nxt = (q == 2'd0) ? rr : (q == 2'd2) ? -rr : '0;
                y_nxt = (q == 2'd1) ? rr : (q == 2'd3) ? -rr : '0;
                z_nxt = {{(ZW-24){resu[15]}}, resu, 8'd0};
                state_nxt = S_ROT;
              end else begin
                state_nxt = S_ZERO;
              end
            end
            default: state_nxt = S_ZERO;
          endcase
        end
      end
      S_ROT, S_VEC: begin
        x_nxt  = s_pos ? x_r - ys : x_r + ys;
        y_nxt  = s_pos ? y_r + xs : y_r - xs;
        z_nxt  = s_pos ? z_r - at : z_r + at;
        it_nxt = it_r + 1'b1;
        if (it_r == STEP_W'(CORDIC_STEPS - 1))
          state_nxt = (state_r == S_ROT) ? S_GAINX : S_MAG;
      end
      S_GAINX: begin
        x_nxt     = scaled + ofs_xq;
        state_nxt = S_GAINY;
      end
      S_GAINY: begin
        y_nxt     = scaled + ofs_yq;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        if (x_r == '0 && y_r == '0) begin
          rng_nxt   = '0;
          th_nxt    = '0;
          state_nxt = S_BIN;
        end else begin
          rot_mode_nxt = 1'b0;
          it_nxt       = '0;
          if (x_r[DW-1]) begin
            x_nxt = -x_r;
            y_nxt = -y_r;
            z_nxt = HALF_TURN;
          end else begin
            z_nxt = '0;
          end
          state_nxt = S_VEC;
        end
      end
      S_MAG: begin
        if (rng_s[DW-1])                rng_nxt = '0;
        else if (rng_s > DW'(65535))    rng_nxt = 16'hFFFF;
        else                            rng_nxt = rng_s[15:0];
        th_nxt    = zr[23:8];
        state_nxt = S_BIN;
      end
      S_BIN: begin
        mem_ra    = idx_c;
        idx_nxt   = idx_c;
        state_nxt = S_MRG;
      end
      S_MRG: begin
        mem_ra = idx_r;
        if (out_free) begin
          mem_we        = 1'b1;
          mem_wa        = idx_r;
          mem_wd        = {1'b1, merged};
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'd0, 1'b1, 1'b1, merged, 10'(idx_r)};
          state_nxt     = S_IDLE;
        end
      end
      S_RDW: begin
        mem_ra    = ridx_a;
        state_nxt = S_RDO;
      end
      S_RDO: begin
        mem_ra = ridx_a;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (ridx_ok && mem_rd_r[16])
            out_data_nxt = {4'd0, 1'b0, 1'b1, mem_rd_r[15:0], ridx_r};
          else
            out_data_nxt = {4'd0, 1'b0, 1'b0, 16'd0, ridx_r};
          state_nxt = S_IDLE;
        end
      end
      S_ZERO: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      clr_res_r   <= 1'b0;
      out_valid_r <= 1'b0;
      it_r        <= '0;
      rot_mode_r  <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_res_r   <= clr_res_nxt;
      out_valid_r <= out_valid_nxt;
      it_r        <= it_nxt;
      rot_mode_r  <= rot_mode_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    sel_r      <= sel_nxt;
    ridx_r     <= ridx_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    z_r        <= z_nxt;
    rng_r      <= rng_nxt;
    th_r       <= th_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: rtl/dlsm_checker.sv
// Port checker for the dual lidar scan merge, bound to the top level.
// Depends on dual_lidar_scan_merge_macros.svh.
`include "dual_lidar_scan_merge_macros.svh"

module dlsm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a stalled result word holds
  `DLSM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result word changed while stalled")

  // an empty bucket reports zero range
  `DLSM_ASSERT_NOW(a_empty_zero, out_tvalid && !out_tdata[26], out_tdata[25:10] == 16'd0, "empty bucket with nonzero range")

  // a placed sample always leaves its bucket filled
  `DLSM_ASSERT_NOW(a_placed_filled, out_tvalid && out_tdata[27], out_tdata[26], "placed sample but bucket not filled")

  // one word at a time: busy right after an accept
  `DLSM_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "input taken twice in a row")

endmodule

bind dual_lidar_scan_merge dlsm_checker u_dlsm_checker (.*);
